// ----- rtl/urrb_pkg.sv -----
package urrb_pkg;

	localparam int unsigned DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_EVENT = 2'd1,
		OP_ERROR = 2'd2,
		OP_READ  = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_SUCCESS  = 3'd0,
		ST_RECEIVED = 3'd1,
		ST_FRAMING  = 3'd2,
		ST_PARITY   = 3'd3,
		ST_OVERRUN  = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_UNKNOWN  = 3'd6,
		ST_NODATA   = 3'd7
	} status_e;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
		logic       overrun_flag;
		logic       framing_flag;
		logic       parity_flag;
	} req_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] read_byte;
		logic [2:0] status_code;
	} rsp_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} ctl_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic empty;
		logic full;
	} dp_status_t;

endpackage

// ----- rtl/uart_rx_ring_buffer_top.sv -----
// Receive side of a serial port: a ring buffer of received bytes plus one
// sticky status code.
// The request channel (req_valid, req_stall, req) carries one beat per
// event: a received byte, a receive event, an error event or a user read.
// The response channel (rsp_valid, rsp_stall, rsp) returns exactly one beat
// per request: the popped byte with its valid flag and the status code.
// A request taken at one edge is executed at that edge, and its response is
// shown from the next cycle on.
// Throughput is one beat per cycle unless a response stalls; the response
// register is the only stage, and memory sees at most one access per beat.
// When the receiver stalls a response, the response holds and req_stall
// rises, so no further request is taken until the response is gone.
// Reset empties the buffer (pointers and fill count clear) and sets the
// status to success. The buffer contents are not cleared and need no
// clearing pass; the fill count guards every read.
module uart_rx_ring_buffer_top
	import urrb_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t   cmd;
	dp_status_t dp_st;

	urrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	urrb_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp),
		.status (dp_st)
	);

	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(dp_st.full && dp_st.empty))
		else $error("buffer reports full and empty at once");

	a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp_valid)
		else $error("executed request produced no response");

	a_byte_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (req.op == OP_BYTE) |=> !dp_st.empty)
		else $error("buffer empty after a received byte");

	a_empty_read_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (req.op == OP_READ) && dp_st.empty |=> !rsp.byte_valid)
		else $error("read of empty buffer returned a byte");

endmodule

// ----- rtl/urrb_ctrl.sv -----
module urrb_ctrl
	import urrb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// A new beat is taken whenever the result register is empty or being drained.
	assign req_stall = (state_q == S_HOLD) && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = (state_q == S_HOLD);
	assign cmd.exec  = accept;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_HOLD;
				end
			end
			S_HOLD: begin
				if (accept) begin
					state_d = S_HOLD;
				end else if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/urrb_datapath.sv -----
module urrb_datapath
	import urrb_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	input  req_t       req,
	output rsp_t       rsp,
	output dp_status_t status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	status_e       port_status_q;
	logic          bvalid_q;
	logic [7:0]    rdata_q;
	logic [2:0]    code_q;

	logic    empty;
	logic    full;
	logic    do_write;
	logic    do_read;
	status_e status_d;
	status_e code_d;
	op_e     op;

	assign op    = op_e'(req.op);
	assign empty = (count_q == '0);
	assign full  = (count_q == FULL_CNT);

	assign status.empty = empty;
	assign status.full  = full;

	assign do_write = cmd.exec && (op == OP_BYTE) && !full;
	assign do_read  = cmd.exec && (op == OP_READ) && !empty;

	always_comb begin
		status_d = port_status_q;
		code_d   = port_status_q;
		case (op)
			OP_BYTE: begin
				status_d = full ? ST_OVERFLOW : ST_RECEIVED;
				code_d   = status_d;
			end
			OP_EVENT: begin
				status_d = ST_UNKNOWN;
				code_d   = status_d;
			end
			OP_ERROR: begin
				if (req.overrun_flag) begin
					status_d = ST_OVERRUN;
				end else if (req.framing_flag) begin
					status_d = ST_FRAMING;
				end else if (req.parity_flag) begin
					status_d = ST_PARITY;
				end else begin
					status_d = ST_UNKNOWN;
				end
				code_d = status_d;
			end
			OP_READ: begin
				if (!empty) begin
					// The last buffered byte leaves: a plain "received" goes back to success.
					if ((count_q == CW'(1)) && (port_status_q == ST_RECEIVED)) begin
						status_d = ST_SUCCESS;
					end
					code_d = status_d;
				end else if (port_status_q == ST_SUCCESS) begin
					code_d = ST_NODATA;
				end else begin
					code_d   = port_status_q;
					status_d = ST_SUCCESS;
				end
			end
			default: begin
				status_d = port_status_q;
				code_d   = port_status_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_ptr_q] <= req.rx_byte;
		end
		if (do_read) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			code_q <= code_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			count_q       <= '0;
			port_status_q <= ST_SUCCESS;
			bvalid_q      <= 1'b0;
		end else begin
			if (cmd.exec) begin
				port_status_q <= status_d;
				bvalid_q      <= do_read;
			end
			if (do_write) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
				count_q  <= count_q + CW'(1);
			end
			if (do_read) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
				count_q  <= count_q - CW'(1);
			end
		end
	end

	assign rsp.byte_valid  = bvalid_q;
	assign rsp.read_byte   = bvalid_q ? rdata_q : 8'd0;
	assign rsp.status_code = code_q;

endmodule
